>>> design/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on clk, switched off while arst_n is low.
`define SEP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same, but also live during reset.
`define SEP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> design/sep_pkg.sv
// Shared types and constants of the stale entry poll selector.
`timescale 1ns / 1ps

package sep_pkg;

	localparam int DEF_NUM_ENTRIES = 33;

	localparam int CMD_W   = 3;
	localparam int INDEX_W = 6;
	localparam int STAMP_W = 32;
	localparam int MODE_W  = 2;

	typedef logic [CMD_W-1:0]   cmd_t;
	typedef logic [INDEX_W-1:0] index_t;
	typedef logic [STAMP_W-1:0] stamp_t;
	typedef logic [MODE_W-1:0]  mode_t;

	localparam cmd_t CMD_SET_MODES  = 3'd0;
	localparam cmd_t CMD_SET_STAMPS = 3'd1;
	localparam cmd_t CMD_TOUCH      = 3'd2;
	localparam cmd_t CMD_OLDEST     = 3'd3;
	localparam cmd_t CMD_NEWEST     = 3'd4;

	localparam mode_t MODE_IGNORE = 2'd0;
	localparam mode_t MODE_ONCE   = 2'd1;

	localparam stamp_t STAMP_ALL_ONES = '1;

	// Write enables into the entry store.
	typedef struct packed {
		logic stamp_we;
		logic mode_we;
	} store_wr_t;

	// Control of the shared compare unit.
	typedef struct packed {
		logic start;
		logic newest;
		logic en;
	} scan_ctl_t;

endpackage

>>> design/sep_store.sv
// Entry store: stamp and mode memories, one shared address, registered read.
`timescale 1ns / 1ps

module sep_store #(
	parameter int NUM_ENTRIES = sep_pkg::DEF_NUM_ENTRIES,
	localparam int ADDR_W = $clog2(NUM_ENTRIES)
) (
	input  logic               clk,
	input  sep_pkg::store_wr_t wr,
	input  logic [ADDR_W-1:0]  addr,
	input  sep_pkg::stamp_t    wr_stamp,
	input  sep_pkg::mode_t     wr_mode,
	output sep_pkg::stamp_t    rd_stamp_q,
	output sep_pkg::mode_t     rd_mode_q
);

	sep_pkg::stamp_t stamp_mem [NUM_ENTRIES];
	sep_pkg::mode_t  mode_mem  [NUM_ENTRIES];

	always_ff @(posedge clk) begin
		if (wr.stamp_we) begin
			stamp_mem[addr] <= wr_stamp;
		end
		rd_stamp_q <= stamp_mem[addr];
	end

	always_ff @(posedge clk) begin
		if (wr.mode_we) begin
			mode_mem[addr] <= wr_mode;
		end
		rd_mode_q <= mode_mem[addr];
	end

endmodule

>>> design/sep_scan_unit.sv
// Shared compare unit: running oldest/newest search over streamed entries.
`timescale 1ns / 1ps

module sep_scan_unit #(
	parameter int NUM_ENTRIES = sep_pkg::DEF_NUM_ENTRIES,
	localparam int ADDR_W = $clog2(NUM_ENTRIES),
	localparam int PICK_W = $clog2(NUM_ENTRIES + 1)
) (
	input  logic               clk,
	input  sep_pkg::scan_ctl_t ctl,
	input  sep_pkg::mode_t     filter,
	input  logic [ADDR_W-1:0]  slot,
	input  sep_pkg::stamp_t    rd_stamp,
	input  sep_pkg::mode_t     rd_mode,
	output logic [PICK_W-1:0]  pick_q
);

	sep_pkg::stamp_t best_q;
	logic            newest_q;
	sep_pkg::stamp_t cmp_a;
	sep_pkg::stamp_t cmp_b;
	logic            better;
	logic            match;

	// one magnitude comparator; operands swap for the newest search
	always_comb begin
		cmp_a  = newest_q ? rd_stamp : best_q;
		cmp_b  = newest_q ? best_q : rd_stamp;
		better = (cmp_a > cmp_b);
		match  = (filter == sep_pkg::MODE_IGNORE) || (rd_mode == filter);
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			newest_q <= ctl.newest;
			best_q   <= ctl.newest ? '0 : sep_pkg::STAMP_ALL_ONES;
			pick_q   <= PICK_W'(NUM_ENTRIES);
		end else if (ctl.en && match && better) begin
			best_q <= rd_stamp;
			pick_q <= PICK_W'(slot);
		end
	end

endmodule

>>> design/stale_entry_poll_selector.sv
// Top level of the stale entry poll selector: sequencer, store, compare unit, result register.
`timescale 1ns / 1ps

// Keeps NUM_ENTRIES entries, each a 32-bit last-fetch stamp and a 2-bit monitor
// mode, in two single-port memories, and answers one result item per input item.
// One item is worked on at a time; in_ready is high only while the sequencer is
// idle, and a new item may be taken while the previous result still waits on
// the output register. Work between acceptance and the return of in_ready:
//   set all modes / set all stamps : one memory write a cycle over every entry
//   touch, entry in range          : read old mode, write back, finish
//   touch out of range, unused cmd : finish only
//   oldest / newest query          : one entry a cycle through the single read
//                                    port and one comparator, then a drain state
//                                    for the registered read
// Finishing waits while the output register is still full. After reset the
// block runs a clearing pass, zeroing every stamp and mode, before it raises
// in_ready. Queries use strict compares, so ties go to the lower index; an
// all-ones stamp never wins oldest, a zero stamp never wins newest, and
// NUM_ENTRIES (cut to 6 bits) means no entry qualified.
module stale_entry_poll_selector #(
	parameter int NUM_ENTRIES = sep_pkg::DEF_NUM_ENTRIES
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  sep_pkg::cmd_t     cmd,
	input  sep_pkg::index_t   entry_index,
	input  sep_pkg::stamp_t   tick_stamp,
	input  sep_pkg::mode_t    mode_code,
	output logic              out_valid,
	input  logic              out_ready,
	output sep_pkg::index_t   picked_index,
	output logic              accepted
);

	localparam int ADDR_W = $clog2(NUM_ENTRIES);
	localparam int PICK_W = $clog2(NUM_ENTRIES + 1);

	typedef enum logic [7:0] {
		ST_CLEAR    = 8'b0000_0001,
		ST_IDLE     = 8'b0000_0010,
		ST_SWEEP    = 8'b0000_0100,
		ST_TOUCH_RD = 8'b0000_1000,
		ST_TOUCH_WR = 8'b0001_0000,
		ST_SCAN     = 8'b0010_0000,
		ST_DRAIN    = 8'b0100_0000,
		ST_FINISH   = 8'b1000_0000
	} state_t;

	state_t             state_q;
	state_t             state_d;
	logic [ADDR_W-1:0]  addr_q;
	logic [ADDR_W-1:0]  addr_d;
	logic               addr_last;
	logic               accept;
	logic               idx_ok;
	logic               out_free;
	logic               finish;

	// item held for the duration of its work
	sep_pkg::cmd_t      cmd_q;
	sep_pkg::stamp_t    stamp_q;
	sep_pkg::mode_t     mode_q;
	logic               acc_q;

	// read-to-compare pipeline
	logic               cmp_vld_s1;
	logic [ADDR_W-1:0]  cmp_slot_s1;

	// result register
	logic               out_valid_q;
	sep_pkg::index_t    picked_q;
	logic               accepted_q;

	sep_pkg::store_wr_t store_wr;
	sep_pkg::stamp_t    wr_stamp;
	sep_pkg::mode_t     wr_mode;
	sep_pkg::stamp_t    rd_stamp;
	sep_pkg::mode_t     rd_mode;
	sep_pkg::scan_ctl_t scan_ctl;
	logic [PICK_W-1:0]  pick;
	logic               is_query;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign idx_ok    = (int'(entry_index) < NUM_ENTRIES);
	assign addr_last = (addr_q == ADDR_W'(NUM_ENTRIES - 1));
	assign out_free  = !out_valid_q || out_ready;
	assign finish    = (state_q == ST_FINISH) && out_free;
	assign is_query  = (cmd_q == sep_pkg::CMD_OLDEST) || (cmd_q == sep_pkg::CMD_NEWEST);

	// sequencer
	always_comb begin
		state_d = state_q;
		addr_d  = addr_q;
		case (state_q)
			ST_CLEAR: begin
				addr_d = addr_last ? '0 : addr_q + 1'b1;
				if (addr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					addr_d = '0;
					case (cmd)
						sep_pkg::CMD_SET_MODES,
						sep_pkg::CMD_SET_STAMPS: state_d = ST_SWEEP;
						sep_pkg::CMD_TOUCH: begin
							if (idx_ok) begin
								state_d = ST_TOUCH_RD;
								addr_d  = ADDR_W'(entry_index);
							end else begin
								state_d = ST_FINISH;
							end
						end
						sep_pkg::CMD_OLDEST,
						sep_pkg::CMD_NEWEST: state_d = ST_SCAN;
						default: state_d = ST_FINISH;
					endcase
				end
			end
			ST_SWEEP: begin
				addr_d = addr_last ? '0 : addr_q + 1'b1;
				if (addr_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_TOUCH_RD: state_d = ST_TOUCH_WR;
			ST_TOUCH_WR: state_d = ST_FINISH;
			ST_SCAN: begin
				addr_d = addr_last ? '0 : addr_q + 1'b1;
				if (addr_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: state_d = ST_FINISH;
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			addr_q      <= '0;
			cmp_vld_s1  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			addr_q     <= addr_d;
			cmp_vld_s1 <= (state_q == ST_SCAN);
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cmp_slot_s1 <= addr_q;
		if (accept) begin
			cmd_q   <= cmd;
			stamp_q <= tick_stamp;
			mode_q  <= mode_code;
			acc_q   <= 1'b0;
		end else if (state_q == ST_TOUCH_WR) begin
			acc_q <= (rd_mode != sep_pkg::MODE_IGNORE);
		end
		if (finish) begin
			picked_q   <= is_query ? sep_pkg::index_t'(pick) : '0;
			accepted_q <= acc_q;
		end
	end

	// store writes: clearing pass, broadcast sweep, touch write-back
	always_comb begin
		store_wr.stamp_we = (state_q == ST_CLEAR) || (state_q == ST_TOUCH_WR) ||
			((state_q == ST_SWEEP) && (cmd_q == sep_pkg::CMD_SET_STAMPS));
		store_wr.mode_we  = (state_q == ST_CLEAR) ||
			((state_q == ST_SWEEP) && (cmd_q == sep_pkg::CMD_SET_MODES)) ||
			((state_q == ST_TOUCH_WR) && (rd_mode == sep_pkg::MODE_ONCE));
		wr_stamp = (state_q == ST_CLEAR) ? '0 : stamp_q;
		wr_mode  = (state_q == ST_SWEEP) ? mode_q : sep_pkg::MODE_IGNORE;
	end

	assign scan_ctl.start  = accept;
	assign scan_ctl.newest = (cmd == sep_pkg::CMD_NEWEST);
	assign scan_ctl.en     = cmp_vld_s1;

	sep_store #(
		.NUM_ENTRIES (NUM_ENTRIES)
	) u_store (
		.clk        (clk),
		.wr         (store_wr),
		.addr       (addr_q),
		.wr_stamp   (wr_stamp),
		.wr_mode    (wr_mode),
		.rd_stamp_q (rd_stamp),
		.rd_mode_q  (rd_mode)
	);

	sep_scan_unit #(
		.NUM_ENTRIES (NUM_ENTRIES)
	) u_scan (
		.clk      (clk),
		.ctl      (scan_ctl),
		.filter   (mode_q),
		.slot     (cmp_slot_s1),
		.rd_stamp (rd_stamp),
		.rd_mode  (rd_mode),
		.pick_q   (pick)
	);

	assign out_valid    = out_valid_q;
	assign picked_index = picked_q;
	assign accepted     = accepted_q;

endmodule

>>> design/sep_checker.sv
// Port-level checker for the stale entry poll selector, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sep_checker #(
	parameter int NUM_ENTRIES = sep_pkg::DEF_NUM_ENTRIES
) (
	input logic            clk,
	input logic            arst_n,
	input logic            in_valid,
	input logic            in_ready,
	input logic            out_valid,
	input logic            out_ready,
	input sep_pkg::index_t picked_index,
	input logic            accepted
);

	// a held result keeps its value
	`SEP_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(picked_index) && $stable(accepted), "result changed while stalled")

	// one item at a time: busy right after an acceptance
	`SEP_ASSERT(a_busy_after_accept, in_valid && in_ready |=> !in_ready, "took two items back to back")

	// only a touch sets accepted, and a touch picks nothing
	`SEP_ASSERT(a_touch_no_pick, out_valid && accepted |-> picked_index == '0, "touch result with a pick")

	// a pick never lies past the entry count
	`SEP_ASSERT(a_pick_range, out_valid |-> (NUM_ENTRIES > 63) || (int'(picked_index) <= NUM_ENTRIES), "picked index beyond entry count")

	// nothing is offered while in reset
	`SEP_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid && !in_ready, "handshake live during reset")

endmodule

bind stale_entry_poll_selector sep_checker #(
	.NUM_ENTRIES (NUM_ENTRIES)
) u_sep_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.picked_index (picked_index),
	.accepted     (accepted)
);
